@@ hw/rtl/emf_pkg.sv @@
// Shared types and constants for the exact motif first-match search.
// Used by emf_cell, emf_outbuf and exact_motif_first_match; no dependencies.
`default_nettype none

package emf_pkg;

    localparam int MOTIF_MAX    = 32;
    localparam int MAX_SEQUENCE = 1048576;

    localparam int SYM_W      = 8;
    localparam int CNT_W      = $clog2(MOTIF_MAX + 1);
    localparam int POS_W      = $clog2(MAX_SEQUENCE + 1);
    localparam int OUT_POS_W  = 21;
    localparam int OUT_DATA_W = 24;

    typedef logic [SYM_W-1:0] sym_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEQ    = 2'd2
    } op_t;

    // per-cycle shift controls for the cell row
    typedef struct packed {
        logic shift_win;
        logic shift_mot;
    } cell_ctl_t;

    // one result item, match_position in the lowest bits
    typedef struct packed {
        logic                 too_long;
        logic                 found;
        logic [OUT_POS_W-1:0] match_position;
    } result_t;

    localparam int PAD_W = OUT_DATA_W - $bits(result_t);

endpackage

`default_nettype wire

@@ hw/rtl/exact_motif_first_match.sv @@
// Top level: exact first-occurrence motif search over a symbol stream.
// Depends on emf_pkg, emf_cell, emf_outbuf.
`default_nettype none

// Throughput: one item (motif op or sequence symbol) per cycle, sustained while
//   the output skid stage is empty. The result of the last-marked sequence symbol
//   is registered in the output buffer; only that symbol produces a result.
// The whole window is compared in the accept cycle by the row of cells.
// Reset: asynchronous, active low; clears motif count, position, match and
//   overflow state. Motif and window symbols are not reset (never read
//   before written within a run).
module exact_motif_first_match (
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,
    input  wire  logic                              s_axis_tvalid,
    output       logic                              s_axis_tready,
    input  wire  logic [7:0]                        s_axis_tdata,  // [7:0] symbol
    input  wire  logic                              s_axis_tlast,  // last sequence symbol
    input  wire  logic [1:0]                        s_axis_tuser,  // [1:0] operation
    output       logic                              m_axis_tvalid,
    input  wire  logic                              m_axis_tready,
    // [20:0] match_position, [21] found, [22] too_long, [23] zero
    output       logic [emf_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int N = emf_pkg::MOTIF_MAX;

    logic                       in_fire;
    emf_pkg::op_t               op;
    logic                       is_clear;
    logic                       is_append;
    logic                       is_seq;
    logic                       sat;
    emf_pkg::cell_ctl_t         ctl;

    logic [emf_pkg::CNT_W-1:0]  mc_reg;
    logic [emf_pkg::CNT_W-1:0]  mc_next;
    logic [emf_pkg::POS_W-1:0]  pos_reg;
    logic [emf_pkg::POS_W-1:0]  pos_next;
    logic [emf_pkg::POS_W-1:0]  pos_inc;
    logic                       seen_reg;
    logic                       seen_next;
    logic [emf_pkg::POS_W-1:0]  start_reg;
    logic [emf_pkg::POS_W-1:0]  start_next;
    logic                       ovf_reg;
    logic                       ovf_next;

    emf_pkg::sym_t              win_chain [N+1];
    emf_pkg::sym_t              mot_chain [N+1];
    logic [N-1:0]               hit;
    logic [N-1:0]               active;
    logic                       window_match;

    logic                       res_valid;
    emf_pkg::result_t           res;
    emf_pkg::result_t           m_data;
    logic                       buf_ready;
    logic [31:0]                pos_wide;

    assign s_axis_tready = buf_ready;
    assign in_fire       = s_axis_tvalid && buf_ready;
    assign op            = emf_pkg::op_t'(s_axis_tuser);

    always_comb
    begin
        is_clear  = 1'b0;
        is_append = 1'b0;
        is_seq    = 1'b0;
        case (op)
            emf_pkg::OP_CLEAR:  is_clear  = 1'b1;
            emf_pkg::OP_APPEND: is_append = 1'b1;
            emf_pkg::OP_SEQ:    is_seq    = 1'b1;
            default:            ;   // unused code: no effect
        endcase
    end

    // position counter saturates at the sequence limit
    assign sat     = (pos_reg >= emf_pkg::POS_W'(emf_pkg::MAX_SEQUENCE));
    assign pos_inc = pos_reg + emf_pkg::POS_W'(1);

    // motif enters at cell 0 so cell j holds motif[count-1-j], lining up
    // with the window symbol of age j
    assign ctl.shift_mot = in_fire && is_append && (mc_reg < emf_pkg::CNT_W'(N));
    assign ctl.shift_win = in_fire && is_seq && !sat;

    assign win_chain[0] = s_axis_tdata;
    assign mot_chain[0] = s_axis_tdata;

    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_cell
            assign active[j] = (mc_reg > emf_pkg::CNT_W'(j));
            emf_cell u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .win_in  (win_chain[j]),
                .mot_in  (mot_chain[j]),
                .active  (active[j]),
                .win_out (win_chain[j+1]),
                .mot_out (mot_chain[j+1]),
                .hit     (hit[j])
            );
        end
    endgenerate

    // empty motif and a motif longer than the symbols seen never match
    assign window_match = (&hit) && (mc_reg != '0)
                          && (pos_inc >= emf_pkg::POS_W'(mc_reg));

    always_comb
    begin
        mc_next    = mc_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        start_next = start_reg;
        ovf_next   = ovf_reg;
        res_valid  = 1'b0;

        if (in_fire && is_clear)
        begin
            mc_next = '0;
        end
        if (ctl.shift_mot)
        begin
            mc_next = mc_reg + emf_pkg::CNT_W'(1);
        end

        if (in_fire && is_seq)
        begin
            if (sat)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                pos_next = pos_inc;
                if (!seen_reg && window_match)
                begin
                    seen_next  = 1'b1;
                    start_next = pos_inc - emf_pkg::POS_W'(mc_reg);
                end
            end
        end

        pos_wide           = 32'(seen_next ? start_next : pos_next);
        res.match_position = pos_wide[emf_pkg::OUT_POS_W-1:0];
        res.found          = seen_next;
        res.too_long       = ovf_next;

        // end of sequence: report, then clear for the next run (motif kept)
        if (in_fire && is_seq && s_axis_tlast)
        begin
            res_valid  = 1'b1;
            pos_next   = '0;
            seen_next  = 1'b0;
            start_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mc_reg    <= '0;
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            mc_reg    <= mc_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
            start_reg <= start_next;
            ovf_reg   <= ovf_next;
        end
    end

    emf_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .ready     (buf_ready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_data)
    );

    assign m_axis_tdata = {{emf_pkg::PAD_W{1'b0}}, m_data};

    a_mc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mc_reg <= emf_pkg::CNT_W'(N))
        else $error("motif count beyond capacity");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= emf_pkg::POS_W'(emf_pkg::MAX_SEQUENCE))
        else $error("position counter passed saturation");

    a_start_before_pos: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (start_reg < pos_reg))
        else $error("recorded match start not below position");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_seq && s_axis_tlast) |=> m_axis_tvalid)
        else $error("end of sequence did not produce a result item");

endmodule

`default_nettype wire

@@ hw/rtl/emf_cell.sv @@
// One cell of the search row: one window symbol and one motif symbol.
// Depends on emf_pkg.
`default_nettype none

module emf_cell (
    input  wire                logic clk,
    input  wire emf_pkg::cell_ctl_t  ctl,
    input  wire emf_pkg::sym_t       win_in,   // from the newer neighbor
    input  wire emf_pkg::sym_t       mot_in,
    input  wire                logic active,   // cell lies inside the motif
    output      emf_pkg::sym_t       win_out,
    output      emf_pkg::sym_t       mot_out,
    output      logic                hit
);

    emf_pkg::sym_t win_reg;
    emf_pkg::sym_t mot_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift_win)
        begin
            win_reg <= win_in;
        end
        if (ctl.shift_mot)
        begin
            mot_reg <= mot_in;
        end
    end

    // compare the symbol moving in this cycle against the aligned motif symbol
    assign hit     = !active || (win_in == mot_reg);
    assign win_out = win_reg;
    assign mot_out = mot_reg;

endmodule

`default_nettype wire

@@ hw/rtl/emf_outbuf.sv @@
// Output register with a skid stage for result items.
// Depends on emf_pkg.
`default_nettype none

module emf_outbuf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_valid,
    input  wire emf_pkg::result_t res,
    output      logic             ready,
    output      logic             m_valid,
    input  wire logic             m_ready,
    output      emf_pkg::result_t m_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    emf_pkg::result_t out_data_reg;
    emf_pkg::result_t out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    emf_pkg::result_t skid_data_reg;
    emf_pkg::result_t skid_data_next;
    logic             out_fire;

    assign out_fire = out_valid_reg && m_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign ready   = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while the output register is empty");

endmodule

`default_nettype wire
